>>> rtl/bce_pkg.sv
// Shared types and constants of the Bezier curve evaluator.
package bce_pkg;

	typedef enum logic {
		OpAppend = 1'b0,
		OpEval   = 1'b1
	} op_e;

	localparam int unsigned BinomN = 16;
	localparam int unsigned CoefW  = 13;
	localparam int unsigned TW     = 17;
	localparam int unsigned CoordW = 16;

	localparam logic [TW-1:0] OneQ16 = 17'h10000;

	typedef logic [BinomN-1:0][BinomN-1:0][CoefW-1:0] binom_tab_t;

	// Pascal's triangle, built at elaboration.
	function automatic binom_tab_t build_binom();
		binom_tab_t tab;
		tab = '0;
		tab[0][0] = CoefW'(1);
		for (int r = 1; r < BinomN; r++) begin
			tab[r][0] = CoefW'(1);
			for (int k = 1; k <= r; k++) begin
				tab[r][k] = tab[r-1][k-1] + tab[r-1][k];
			end
		end
		return tab;
	endfunction

	localparam binom_tab_t BinomTab = build_binom();

endpackage

>>> rtl/bce_ifs.sv
// Valid/ready channel interfaces for the Bezier curve evaluator.
interface bce_item_if;
	import bce_pkg::*;

	logic                     valid;
	logic                     ready;
	op_e                      operation;
	logic signed [CoordW-1:0] point_x;
	logic signed [CoordW-1:0] point_y;
	logic [TW-1:0]            sample_t;

	modport source (output valid, operation, point_x, point_y, sample_t, input ready);
	modport sink (input valid, operation, point_x, point_y, sample_t, output ready);
endinterface

interface bce_result_if;
	import bce_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [CoordW-1:0] curve_x;
	logic signed [CoordW-1:0] curve_y;

	modport source (output valid, curve_x, curve_y, input ready);
	modport sink (input valid, curve_x, curve_y, output ready);
endinterface

>>> rtl/bezier_curve_evaluator.sv
// Bezier curve evaluator: control point store and Bernstein-form evaluation.
//
// An append beat is accepted back to back. An evaluate beat over n stored
// points keeps the input stalled after it is accepted, also while it waits
// for the previous result to be taken: the Build state fills the table of
// powers of (1 - t) through the shared 17x17 power multiplier, the Run state
// streams the points and powers out of the two memories into a four-stage
// weight and product pipeline, the Drain state empties that pipeline and the
// Finish state rounds the sum. With no points stored the evaluation goes
// straight to the Finish state. The result waits in an output register, so
// the next beat can be accepted while it is still pending.
module bezier_curve_evaluator #(
	parameter int unsigned MAX_POINTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	bce_item_if.sink     item,
	bce_result_if.source result
);
	import bce_pkg::*;

	localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned CW = $clog2(MAX_POINTS + 1);
	localparam int unsigned AccW = 48;
	localparam int unsigned PrW = CoefW + TW + CoordW + 1;

	typedef enum logic [2:0] {Idle, Build, Run, Drain, Finish} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] m_q;
	logic [AW-1:0] idx_q;
	logic [TW-1:0] t_q;
	logic [TW-1:0] u_q;
	logic [TW-1:0] pw_q;
	logic signed [AccW-1:0] acc_q;
	logic signed [AccW-1:0] acc_y_q;
	logic out_valid_q;
	logic signed [CoordW-1:0] cx_q;
	logic signed [CoordW-1:0] cy_q;

	logic accept;
	logic out_free;
	logic [TW-1:0] t_sat;
	logic [TW-1:0] pw_base;
	logic [2*TW-1:0] pw_prod;

	logic pt_we;
	logic [2*CoordW-1:0] pt_rd;
	logic up_we;
	logic [AW-1:0] up_raddr;
	logic [TW-1:0] up_rd;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [TW-1:0] tp_s1;
	logic [CoefW-1:0] coef_s1, coef_s2;
	logic [TW-1:0] w_s2;
	logic [2*TW-1:0] w_prod;
	logic [2*CoordW-1:0] pt_s2;
	logic [CoefW+TW-1:0] wc_s3;
	logic signed [CoordW-1:0] px_s3, py_s3;
	logic signed [PrW-1:0] prx_s4, pry_s4;

	function automatic logic signed [CoordW-1:0] round_sat(input logic signed [AccW-1:0] s);
		logic signed [AccW-1:0] b;
		logic signed [AccW-17:0] q;
		b = s + AccW'(32768);
		q = b[AccW-1:16];
		if (q > (AccW-16)'(32767)) begin
			return 16'sh7fff;
		end else if (q < -(AccW-16)'(32768)) begin
			return 16'sh8000;
		end
		return q[CoordW-1:0];
	endfunction

	assign accept     = item.valid && item.ready;
	assign item.ready = (state_q == Idle);
	assign out_free   = !out_valid_q || result.ready;

	assign result.valid   = out_valid_q;
	assign result.curve_x = cx_q;
	assign result.curve_y = cy_q;

	assign t_sat   = (item.sample_t > OneQ16) ? OneQ16 : item.sample_t;
	assign pw_base = (state_q == Build) ? u_q : t_q;
	assign pw_prod = pw_q * pw_base;

	assign pt_we    = accept && (item.operation == OpAppend) && (count_q < CW'(MAX_POINTS));
	assign up_we    = (state_q == Build);
	assign up_raddr = m_q - idx_q;

	bce_ram #(
		.Width(2 * CoordW),
		.Depth(MAX_POINTS)
	) u_point_ram (
		.clk  (clk),
		.we   (pt_we),
		.waddr(count_q[AW-1:0]),
		.wdata({item.point_x, item.point_y}),
		.raddr(idx_q),
		.rdata(pt_rd)
	);

	bce_ram #(
		.Width(TW),
		.Depth(MAX_POINTS)
	) u_power_ram (
		.clk  (clk),
		.we   (up_we),
		.waddr(idx_q),
		.wdata(pw_q),
		.raddr(up_raddr),
		.rdata(up_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= Idle;
			count_q     <= '0;
			m_q         <= '0;
			idx_q       <= '0;
			t_q         <= '0;
			u_q         <= '0;
			pw_q        <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == Finish) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				Idle: begin
					if (accept) begin
						if (item.operation == OpAppend) begin
							if (pt_we) begin
								count_q <= count_q + CW'(1);
							end
						end else if (count_q == '0) begin
							state_q <= Finish;
						end else begin
							t_q     <= t_sat;
							u_q     <= OneQ16 - t_sat;
							m_q     <= AW'(count_q - CW'(1));
							pw_q    <= OneQ16;
							idx_q   <= '0;
							state_q <= Build;
						end
					end
				end
				Build: begin
					if (idx_q == m_q) begin
						idx_q   <= '0;
						pw_q    <= OneQ16;
						state_q <= Run;
					end else begin
						pw_q  <= pw_prod[TW+15:16];
						idx_q <= idx_q + AW'(1);
					end
				end
				Run: begin
					pw_q <= pw_prod[TW+15:16];
					if (idx_q == m_q) begin
						state_q <= Drain;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				Drain: begin
					if (!(v_s1 || v_s2 || v_s3 || v_s4)) begin
						state_q <= Finish;
					end
				end
				Finish: begin
					if (out_free) begin
						cx_q    <= round_sat(acc_q);
						cy_q    <= round_sat(acc_y_q);
						state_q <= Idle;
					end
				end
				default: begin
					state_q <= Idle;
				end
			endcase
		end
	end

	assign w_prod = tp_s1 * up_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= (state_q == Run);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		tp_s1   <= pw_q;
		coef_s1 <= BinomTab[4'(m_q)][4'(idx_q)];

		w_s2    <= w_prod[TW+15:16];
		coef_s2 <= coef_s1;
		pt_s2   <= pt_rd;

		wc_s3 <= coef_s2 * w_s2;
		px_s3 <= pt_s2[2*CoordW-1:CoordW];
		py_s3 <= pt_s2[CoordW-1:0];

		prx_s4 <= $signed({1'b0, wc_s3}) * px_s3;
		pry_s4 <= $signed({1'b0, wc_s3}) * py_s3;

		if (accept) begin
			acc_q   <= '0;
			acc_y_q <= '0;
		end else if (v_s4) begin
			acc_q   <= acc_q + AccW'(prx_s4);
			acc_y_q <= acc_y_q + AccW'(pry_s4);
		end
	end

endmodule

>>> rtl/bce_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bce_ram #(
	parameter int unsigned Width = 16,
	parameter int unsigned Depth = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                         wdata,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
